// ===== design/sorted_table_binary_search_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted table binary search: assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define STBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define STBS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary search package
// Field types, command and order codes, FSM states and the result record.
// ----------------------------------------------------------------------------
package stbs_pkg;

  // Payload field types.
  typedef logic [1:0] cmd_t;
  typedef logic [7:0] length_t;
  typedef logic [9:0] index_t;
  typedef logic [1:0] order_t;

  // Command codes.
  localparam cmd_t CMD_CLEAR  = 2'd0;
  localparam cmd_t CMD_APPEND = 2'd1;
  localparam cmd_t CMD_SEARCH = 2'd2;

  // Table order codes.
  localparam order_t ORDER_UNSORTED   = 2'd0;
  localparam order_t ORDER_ASCENDING  = 2'd1;
  localparam order_t ORDER_DESCENDING = 2'd2;

  // Engine states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_COMPARE,
    ST_RESULT
  } state_t;

  // One search result.
  typedef struct packed {
    logic   found;
    index_t match_index;
    order_t table_order;
  } result_t;

endpackage

// ===== design/stbs_channels.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary search channels
// Valid/ready interfaces for the command stream and the result stream.
// ----------------------------------------------------------------------------
interface stbs_in_if;
  logic              valid;
  logic              ready;
  stbs_pkg::cmd_t    cmd;
  stbs_pkg::length_t entry_length;
  stbs_pkg::length_t key_length;

  modport source (output valid, output cmd, output entry_length, output key_length,
                  input ready);
  modport sink   (input valid, input cmd, input entry_length, input key_length,
                  output ready);
endinterface

interface stbs_out_if;
  logic              valid;
  logic              ready;
  logic              found;
  stbs_pkg::index_t  match_index;
  stbs_pkg::order_t  table_order;

  modport source (output valid, output found, output match_index, output table_order,
                  input ready);
  modport sink   (input valid, input found, input match_index, input table_order,
                  output ready);
endinterface

// ===== design/stbs_key_mem.sv =====
// ----------------------------------------------------------------------------
// Key table memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module stbs_key_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/stbs_engine.sv =====
// ----------------------------------------------------------------------------
// Search engine
// Tracks table order on appends and runs the binary search probe loop
// against the key memory, each probe an issue state then a compare state.
// ----------------------------------------------------------------------------
module stbs_engine #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BITS    = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  stbs_in_if.sink                        in_ch,
  stbs_out_if.source                     out_ch,
  output logic                           mem_wr_en,
  output logic [$clog2(TABLE_DEPTH)-1:0] mem_wr_addr,
  output logic [KEY_BITS-1:0]            mem_wr_data,
  output logic                           mem_rd_en,
  output logic [$clog2(TABLE_DEPTH)-1:0] mem_rd_addr,
  input  logic [KEY_BITS-1:0]            mem_rd_data
);
  import stbs_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r;
  logic                saw_rise_r;
  logic                saw_fall_r;
  logic [KEY_BITS-1:0] last_r;
  logic [KEY_BITS-1:0] key_r;
  order_t              order_r;
  logic [CNT_W-1:0]    lo_r;
  logic [CNT_W-1:0]    hi_r;
  logic [ADDR_W-1:0]   mid_r;
  result_t             res_r;
  result_t             out_r;
  logic                out_valid_r;

  logic                in_fire;
  logic                result_load;
  logic [31:0]         entry_ext;
  logic [31:0]         key_ext;
  logic [31:0]         mid_ext;
  logic [KEY_BITS-1:0] entry_key;
  logic [KEY_BITS-1:0] search_key;
  logic                table_full;
  order_t              order_now;
  logic [CNT_W:0]      mid_sum;
  logic [ADDR_W-1:0]   mid;
  logic                hit;
  logic                go_left;
  logic [CNT_W-1:0]    lo_upd;
  logic [CNT_W-1:0]    hi_upd;
  logic                range_empty;

  // Key values narrowed or widened to the stored key width.
  assign entry_ext  = 32'(in_ch.entry_length);
  assign key_ext    = 32'(in_ch.key_length);
  assign entry_key  = entry_ext[KEY_BITS-1:0];
  assign search_key = key_ext[KEY_BITS-1:0];
  assign mid_ext    = 32'(mid_r);

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign table_full = (count_r >= CNT_W'(TABLE_DEPTH));

  // Table direction from the recorded rises and falls.
  always_comb begin
    if (saw_rise_r && !saw_fall_r) begin
      order_now = ORDER_ASCENDING;
    end else if (saw_fall_r && !saw_rise_r) begin
      order_now = ORDER_DESCENDING;
    end else begin
      order_now = ORDER_UNSORTED;
    end
  end

  // Probe address over the half-open range [lo, hi).
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} - (CNT_W+1)'(1);
  assign mid     = mid_sum[ADDR_W:1];

  // Probe outcome and the narrowed range.
  assign hit     = (mem_rd_data == key_r);
  assign go_left = (order_r == ORDER_ASCENDING) ? (mem_rd_data > key_r)
                                                : (mem_rd_data < key_r);
  assign lo_upd  = go_left ? lo_r : (CNT_W'(mid_r) + CNT_W'(1));
  assign hi_upd  = go_left ? CNT_W'(mid_r) : hi_r;
  assign range_empty = !(lo_upd < hi_upd);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_ch.cmd == CMD_SEARCH)) begin
          state_nxt = (order_now == ORDER_UNSORTED) ? ST_RESULT : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_nxt = ST_COMPARE;
      end
      ST_COMPARE: begin
        state_nxt = (hit || range_empty) ? ST_RESULT : ST_ISSUE;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    mem_rd_en   = 1'b0;
    result_load = 1'b0;
    unique case (state_r)
      ST_IDLE:    in_ch.ready = 1'b1;
      ST_ISSUE:   mem_rd_en   = 1'b1;
      ST_COMPARE: ;
      ST_RESULT:  result_load = !out_valid_r || out_ch.ready;
      default:    ;
    endcase
  end

  // Memory write on an append to a table with room left.
  assign mem_wr_en   = in_fire && (in_ch.cmd == CMD_APPEND) && !table_full;
  assign mem_wr_addr = count_r[ADDR_W-1:0];
  assign mem_wr_data = entry_key;
  assign mem_rd_addr = mid;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Table bookkeeping: clear and append.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      saw_rise_r <= 1'b0;
      saw_fall_r <= 1'b0;
      last_r     <= '0;
    end else if (in_fire) begin
      case (in_ch.cmd)
        CMD_CLEAR: begin
          count_r    <= '0;
          saw_rise_r <= 1'b0;
          saw_fall_r <= 1'b0;
          last_r     <= '0;
        end
        CMD_APPEND: begin
          if (!table_full) begin
            if (count_r != '0) begin
              if (entry_key > last_r) saw_rise_r <= 1'b1;
              if (entry_key < last_r) saw_fall_r <= 1'b1;
            end
            last_r  <= entry_key;
            count_r <= count_r + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Search datapath: range bounds, probe index and staged result.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_fire && in_ch.cmd == CMD_SEARCH) begin
      key_r                 <= search_key;
      order_r               <= order_now;
      lo_r                  <= '0;
      hi_r                  <= count_r;
      res_r.found           <= 1'b0;
      res_r.match_index     <= '0;
      res_r.table_order     <= order_now;
    end
    if (state_r == ST_ISSUE) begin
      mid_r <= mid;
    end
    if (state_r == ST_COMPARE) begin
      lo_r <= lo_upd;
      hi_r <= hi_upd;
      if (hit) begin
        res_r.found       <= 1'b1;
        res_r.match_index <= mid_ext[9:0];
      end
    end
  end

  // Output register; holds a result until its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (result_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_r <= res_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_r.found;
  assign out_ch.match_index = out_r.match_index;
  assign out_ch.table_order = out_r.table_order;

endmodule

// ===== design/sorted_table_binary_search.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary search: clear and append are applied on their transfer.
// A search makes P probes (at most floor(log2(count)) + 1), each an issue state
// then a compare state; its result can transfer in the same cycle as the next
// command. Reset empties the table; stored keys are not cleared.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BITS    = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  stbs_in_if.sink    in_ch,
  stbs_out_if.source out_ch
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic                mem_wr_en;
  logic [ADDR_W-1:0]   mem_wr_addr;
  logic [KEY_BITS-1:0] mem_wr_data;
  logic                mem_rd_en;
  logic [ADDR_W-1:0]   mem_rd_addr;
  logic [KEY_BITS-1:0] mem_rd_data;

  // Control, order tracking and probe loop.
  stbs_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  // Key table storage.
  stbs_key_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (KEY_BITS)
  ) u_key_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

// ===== design/stbs_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary search checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_defines.svh"

module stbs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_found,
  input stbs_pkg::index_t  out_match_index,
  input stbs_pkg::order_t  out_table_order
);
  import stbs_pkg::*;

  // A stalled result stays offered.
  `STBS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `STBS_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_found) && $stable(out_match_index) && $stable(out_table_order), "result changed while stalled")

  // A miss reports index zero.
  `STBS_ASSERT(a_miss_index, out_valid && !out_found |-> out_match_index == '0, "miss with nonzero index")

  // An unsorted table is never searched, so it never matches.
  `STBS_ASSERT(a_unsorted_miss, out_valid && out_table_order == ORDER_UNSORTED |-> !out_found, "match on unsorted table")

  // Reset leaves no result pending.
  `STBS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result pending after reset")

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_found       (out_ch.found),
  .out_match_index (out_ch.match_index),
  .out_table_order (out_ch.table_order)
);
